FILE: rtl/thc_pkg.sv
// ----------------------------------------------------------------------------
// thc_pkg
// Shared types, constants and helper functions for the texture header
// checker and mip-chain size calculator.
// ----------------------------------------------------------------------------
package thc_pkg;

    // Header identifier and byte-order constants.
    localparam logic [63:0] MAGIC_FIRST    = 64'hAB4B_5458_2031_31BB;
    localparam logic [31:0] MAGIC_LAST     = 32'h0D0A_1A0A;
    localparam logic [31:0] BYTE_ORDER     = 32'h0403_0201;

    // Graphics format codes.
    localparam logic [31:0] FMT_COMPRESSED = 32'h0000_0000;
    localparam logic [31:0] FMT_RGB        = 32'h0000_1907;
    localparam logic [31:0] FMT_RGBA       = 32'h0000_1908;
    localparam logic [31:0] FMT_BGRA       = 32'h0000_80E1;

    // Internal format codes for compressed data.
    localparam logic [31:0] IFMT_ETC1      = 32'h0000_8D64;
    localparam logic [31:0] IFMT_ETC2      = 32'h0000_9274;
    localparam logic [31:0] IFMT_ETC2_EAC  = 32'h0000_9278;
    localparam logic [31:0] IFMT_ETC2_A1   = 32'h0000_9276;
    localparam logic [31:0] IFMT_PVR_RGB2  = 32'h0000_8C01;
    localparam logic [31:0] IFMT_PVR_RGB4  = 32'h0000_8C00;
    localparam logic [31:0] IFMT_PVR_RGBA2 = 32'h0000_8C03;
    localparam logic [31:0] IFMT_PVR_RGBA4 = 32'h0000_8C02;

    // Sizes and limits.
    localparam logic [31:0] HDR_BYTES      = 32'd64;
    localparam logic [31:0] MIN_FILE_BYTES = 32'd128;
    localparam int          LVL_W          = 6;
    localparam logic [LVL_W-1:0] SETTLE_LEVELS = LVL_W'(34);

    // Pixel kinds as reported on the result channel.
    typedef enum logic [3:0] {
        PK_RGB       = 4'd0,
        PK_RGBA      = 4'd1,
        PK_BGRA      = 4'd2,
        PK_ETC1      = 4'd3,
        PK_ETC2      = 4'd4,
        PK_ETC2_EAC  = 4'd5,
        PK_ETC2_A1   = 4'd6,
        PK_PVR_RGB2  = 4'd7,
        PK_PVR_RGB4  = 4'd8,
        PK_PVR_RGBA2 = 4'd9,
        PK_PVR_RGBA4 = 4'd10
    } pix_kind_t;

    // Result of the format lookup.
    typedef struct packed {
        logic      hit;
        pix_kind_t kind;
    } kind_sel_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_EXTRA,
        ST_ADD,
        ST_FIT
    } thc_state_t;

    // Map the format and internal format codes to a pixel kind.
    function automatic kind_sel_t kind_of(input logic [31:0] fmt, input logic [31:0] ifmt);
        kind_sel_t sel;
        sel.hit  = 1'b1;
        sel.kind = PK_RGB;
        case (fmt)
            FMT_RGB:  sel.kind = PK_RGB;
            FMT_RGBA: sel.kind = PK_RGBA;
            FMT_BGRA: sel.kind = PK_BGRA;
            FMT_COMPRESSED:
            begin
                case (ifmt)
                    IFMT_ETC1:      sel.kind = PK_ETC1;
                    IFMT_ETC2:      sel.kind = PK_ETC2;
                    IFMT_ETC2_EAC:  sel.kind = PK_ETC2_EAC;
                    IFMT_ETC2_A1:   sel.kind = PK_ETC2_A1;
                    IFMT_PVR_RGB2:  sel.kind = PK_PVR_RGB2;
                    IFMT_PVR_RGB4:  sel.kind = PK_PVR_RGB4;
                    IFMT_PVR_RGBA2: sel.kind = PK_PVR_RGBA2;
                    IFMT_PVR_RGBA4: sel.kind = PK_PVR_RGBA4;
                    default:        sel.hit  = 1'b0;
                endcase
            end
            default: sel.hit = 1'b0;
        endcase
        return sel;
    endfunction

    // Multiplier operand for one dimension of a level.
    function automatic logic [31:0] dim_operand(input pix_kind_t kind, input logic [31:0] d,
                                                input logic is_width);
        logic [31:0] res;
        logic [31:0] d3;
        d3 = d + 32'd3;
        case (kind)
            PK_RGB, PK_RGBA, PK_BGRA:
                res = d;
            PK_PVR_RGB2, PK_PVR_RGBA2:
                res = is_width ? ((d > 32'd16) ? d : 32'd16) : ((d > 32'd8) ? d : 32'd8);
            PK_PVR_RGB4, PK_PVR_RGBA4:
                res = (d > 32'd8) ? d : 32'd8;
            default:
                res = {2'b00, d3[31:2]};
        endcase
        return res;
    endfunction

    // Turn the registered area product into the byte size of one level.
    function automatic logic [31:0] level_scale(input pix_kind_t kind, input logic [31:0] p);
        logic [31:0] res;
        logic [31:0] t;
        t = 32'd0;
        case (kind)
            PK_RGB:
                res = p + {p[30:0], 1'b0};
            PK_RGBA, PK_BGRA:
                res = {p[29:0], 2'b00};
            PK_PVR_RGB2, PK_PVR_RGBA2:
            begin
                t   = {p[30:0], 1'b0} + 32'd7;
                res = {3'b000, t[31:3]};
            end
            PK_PVR_RGB4, PK_PVR_RGBA4:
            begin
                t   = {p[29:0], 2'b00} + 32'd7;
                res = {3'b000, t[31:3]};
            end
            PK_ETC2_EAC:
                res = {p[27:0], 4'b0000};
            default:
                res = {p[28:0], 3'b000};
        endcase
        return res;
    endfunction

    // Byte size of a 1x1 level for each kind.
    function automatic logic [31:0] unit_bytes(input pix_kind_t kind);
        logic [31:0] res;
        case (kind)
            PK_RGB:                    res = 32'd3;
            PK_RGBA, PK_BGRA:          res = 32'd4;
            PK_PVR_RGB2, PK_PVR_RGBA2,
            PK_PVR_RGB4, PK_PVR_RGBA4: res = 32'd32;
            PK_ETC2_EAC:               res = 32'd16;
            default:                   res = 32'd8;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/thc_hdr_if.sv
// ----------------------------------------------------------------------------
// thc_hdr_if
// Valid/ready channel that carries one decoded texture header per beat.
// ----------------------------------------------------------------------------
interface thc_hdr_if;
    logic        valid;
    logic        ready;
    logic [63:0] magic_first;
    logic [31:0] magic_last;
    logic [31:0] byte_order_word;
    logic [31:0] format_code;
    logic [31:0] internal_format_code;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [31:0] face_total;
    logic [31:0] level_total;
    logic [31:0] key_value_bytes;
    logic [31:0] file_bytes;

    modport source (
        output valid, magic_first, magic_last, byte_order_word, format_code,
               internal_format_code, image_width, image_height, face_total,
               level_total, key_value_bytes, file_bytes,
        input  ready
    );

    modport sink (
        input  valid, magic_first, magic_last, byte_order_word, format_code,
               internal_format_code, image_width, image_height, face_total,
               level_total, key_value_bytes, file_bytes,
        output ready
    );
endinterface

FILE: rtl/thc_res_if.sv
// ----------------------------------------------------------------------------
// thc_res_if
// Valid/ready channel that carries one header check result per beat.
// ----------------------------------------------------------------------------
interface thc_res_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [3:0]  pixel_kind;
    logic [31:0] payload_bytes;
    logic [32:0] payload_offset;
    logic [31:0] out_width;
    logic [31:0] out_height;
    logic [31:0] out_levels;

    modport source (
        output valid, accepted, pixel_kind, payload_bytes, payload_offset,
               out_width, out_height, out_levels,
        input  ready
    );

    modport sink (
        input  valid, accepted, pixel_kind, payload_bytes, payload_offset,
               out_width, out_height, out_levels,
        output ready
    );
endinterface

FILE: rtl/texture_header_check_and_mip_size.sv
// ----------------------------------------------------------------------------
// texture_header_check_and_mip_size
// Checks one decoded texture header and sums the byte size of its mip chain
// with a single shared 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   -------  ---------  ------------------------------------------------------
//   hdr      in         identifier, byte order, formats, size, faces, levels,
//                       key-value bytes, file bytes
//   res      out        accepted, pixel kind, payload bytes and offset,
//                       width, height, levels
//
// A header that passes the checks runs through the level loop (ST_RUN), the
// pass for the levels beyond 34 (ST_EXTRA), the final add (ST_ADD) and the
// fit test (ST_FIT) before it reaches the output register. The level loop
// makes one multiplier pass per mip level, for up to 34 levels, and
// accumulates the last product after the last pass. A header that fails a
// check goes straight to the fit test. hdr.ready is high only while the
// sequencer is idle, so a new header is taken only once the previous one has
// been loaded into the output register.
// A finished result waits in the output register, so the next header can
// enter meanwhile; its fit test holds until that register is free.
// Reset (rst_n low, asynchronous) clears the sequencer and the output valid.
//
module texture_header_check_and_mip_size
    import thc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    thc_hdr_if.sink   hdr,
    thc_res_if.source res
);

    // Control state.
    thc_state_t       state_reg, state_next;
    logic             ok_reg, ok_next;
    logic [LVL_W-1:0] n_reg, n_next;
    logic [LVL_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic             res_valid_reg, res_valid_next;

    // Working payload.
    pix_kind_t        kind_reg, kind_next;
    logic [31:0]      w_reg, w_next;
    logic [31:0]      h_reg, h_next;
    logic [31:0]      width_reg, width_next;
    logic [31:0]      height_reg, height_next;
    logic [31:0]      levels_reg, levels_next;
    logic [31:0]      kv_reg, kv_next;
    logic [31:0]      fsize_reg, fsize_next;
    logic [31:0]      prod_reg, prod_next;
    logic [31:0]      sum_reg, sum_next;

    // Result payload.
    logic             r_acc_reg, r_acc_next;
    logic [3:0]       r_kind_reg, r_kind_next;
    logic [31:0]      r_bytes_reg, r_bytes_next;
    logic [32:0]      r_off_reg, r_off_next;
    logic [31:0]      r_w_reg, r_w_next;
    logic [31:0]      r_h_reg, r_h_next;
    logic [31:0]      r_lv_reg, r_lv_next;

    // Shared multiplier and helpers.
    logic [31:0]      mul_a, mul_b, mul_low;
    kind_sel_t        sel;
    logic             hdr_ok;
    logic             hdr_fire;
    logic [33:0]      fit_total;
    logic             fits;
    logic [32:0]      offset;

    assign hdr.ready = (state_reg == ST_IDLE);
    assign hdr_fire  = hdr.valid & hdr.ready;

    // Header checks on the incoming beat.
    assign sel    = kind_of(hdr.format_code, hdr.internal_format_code);
    assign hdr_ok = (hdr.file_bytes >= MIN_FILE_BYTES)
                  && (hdr.magic_first == MAGIC_FIRST)
                  && (hdr.magic_last == MAGIC_LAST)
                  && (hdr.byte_order_word == BYTE_ORDER)
                  && (hdr.face_total == 32'd1)
                  && sel.hit
                  && (hdr.level_total != 32'd0);

    // Multiplier operands: the level dimensions inside the loop, the tail
    // level count and the 1x1 size in the tail pass.
    always_comb
    begin
        mul_a = dim_operand(kind_reg, w_reg, 1'b1);
        mul_b = dim_operand(kind_reg, h_reg, 1'b0);
        if (state_reg == ST_EXTRA)
        begin
            mul_a = (levels_reg > 32'(SETTLE_LEVELS))
                  ? levels_reg - 32'(SETTLE_LEVELS) : 32'd0;
            mul_b = unit_bytes(kind_reg);
        end
    end

    // Shared multiplier; only the low word is ever needed.
    assign mul_low = 32'(mul_a * mul_b);

    // Fit test and data offset, computed without wrap.
    assign offset    = {1'b0, HDR_BYTES} + {1'b0, kv_reg};
    assign fit_total = {1'b0, offset} + {2'b00, sum_reg};
    assign fits      = (fit_total <= {2'b00, fsize_reg});

    // Next state, datapath and output register control.
    always_comb
    begin
        state_next     = state_reg;
        ok_next        = ok_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        res_valid_next = res_valid_reg;
        kind_next      = kind_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        levels_next    = levels_reg;
        kv_next        = kv_reg;
        fsize_next     = fsize_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        r_acc_next     = r_acc_reg;
        r_kind_next    = r_kind_reg;
        r_bytes_next   = r_bytes_reg;
        r_off_next     = r_off_reg;
        r_w_next       = r_w_reg;
        r_h_next       = r_h_reg;
        r_lv_next      = r_lv_reg;

        // The result beat leaves when the sink takes it.
        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (hdr_fire)
                begin
                    ok_next     = hdr_ok;
                    kind_next   = sel.kind;
                    w_next      = hdr.image_width;
                    h_next      = hdr.image_height;
                    width_next  = hdr.image_width;
                    height_next = hdr.image_height;
                    levels_next = hdr.level_total;
                    kv_next     = hdr.key_value_bytes;
                    fsize_next  = hdr.file_bytes;
                    n_next      = (hdr.level_total < 32'(SETTLE_LEVELS))
                                ? hdr.level_total[LVL_W-1:0] : SETTLE_LEVELS;
                    cnt_next    = '0;
                    pend_next   = 1'b0;
                    sum_next    = 32'd0;
                    state_next  = hdr_ok ? ST_RUN : ST_FIT;
                end
            end

            // One level issued to the multiplier per cycle; the previous
            // product is scaled and accumulated in the same cycle.
            ST_RUN:
            begin
                if (pend_reg)
                begin
                    sum_next = sum_reg + level_scale(kind_reg, prod_reg);
                end
                if (cnt_reg != n_reg)
                begin
                    prod_next = mul_low;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + LVL_W'(1);
                    w_next    = (w_reg > 32'd1) ? {1'b0, w_reg[31:1]} : 32'd1;
                    h_next    = (h_reg > 32'd1) ? {1'b0, h_reg[31:1]} : 32'd1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_EXTRA;
                end
            end

            // Levels past the settle point all have the 1x1 size.
            ST_EXTRA:
            begin
                prod_next  = mul_low;
                state_next = ST_ADD;
            end

            // Add the tail levels and the 4-byte size word of each level.
            ST_ADD:
            begin
                sum_next   = sum_reg + prod_reg + {levels_reg[29:0], 2'b00};
                state_next = ST_FIT;
            end

            // Load the output register once it is free.
            ST_FIT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    if (ok_reg && fits)
                    begin
                        r_acc_next   = 1'b1;
                        r_kind_next  = kind_reg;
                        r_bytes_next = sum_reg;
                        r_off_next   = offset;
                        r_w_next     = width_reg;
                        r_h_next     = height_reg;
                        r_lv_next    = levels_reg;
                    end
                    else
                    begin
                        r_acc_next   = 1'b0;
                        r_kind_next  = 4'd0;
                        r_bytes_next = 32'd0;
                        r_off_next   = 33'd0;
                        r_w_next     = 32'd0;
                        r_h_next     = 32'd0;
                        r_lv_next    = 32'd0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ok_reg        <= 1'b0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ok_reg        <= ok_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        width_reg   <= width_next;
        height_reg  <= height_next;
        levels_reg  <= levels_next;
        kv_reg      <= kv_next;
        fsize_reg   <= fsize_next;
        prod_reg    <= prod_next;
        sum_reg     <= sum_next;
        r_acc_reg   <= r_acc_next;
        r_kind_reg  <= r_kind_next;
        r_bytes_reg <= r_bytes_next;
        r_off_reg   <= r_off_next;
        r_w_reg     <= r_w_next;
        r_h_reg     <= r_h_next;
        r_lv_reg    <= r_lv_next;
    end

    // Result channel.
    assign res.valid          = res_valid_reg;
    assign res.accepted       = r_acc_reg;
    assign res.pixel_kind     = r_kind_reg;
    assign res.payload_bytes  = r_bytes_reg;
    assign res.payload_offset = r_off_reg;
    assign res.out_width      = r_w_reg;
    assign res.out_height     = r_h_reg;
    assign res.out_levels     = r_lv_reg;

`ifndef SYNTHESIS
    // The level counter never runs past the level limit.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg <= n_reg))
        else $error("level counter passed its limit");

    // Only headers that passed the checks enter the level loop.
    a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (ok_reg && (n_reg != '0)))
        else $error("level loop entered for a rejected header");

    // A header beat always starts the sequencer.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr.valid && hdr.ready) |=> (state_reg != ST_IDLE))
        else $error("header beat did not start the sequencer");

    // A rejected result carries only zero fields.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !r_acc_reg) |-> ((r_kind_reg == 4'd0) && (r_bytes_reg == 32'd0)
            && (r_off_reg == 33'd0) && (r_w_reg == 32'd0) && (r_h_reg == 32'd0)
            && (r_lv_reg == 32'd0)))
        else $error("rejected result carries nonzero fields");

    // A product is pending only inside the level loop.
    a_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_RUN) || (state_reg == ST_EXTRA))
        else $error("level product pending outside the loop");
`endif

endmodule

FILE: verif/thc_tb_pkg.sv
// ----------------------------------------------------------------------------
// thc_tb_pkg
// Beat types for the header and result channels, and a scoreboard that works
// out the check outcome and mip-chain byte count of every header beat and
// compares each result beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package thc_tb_pkg;
    import thc_pkg::*;

    typedef struct {
        logic [63:0] magic_first;
        logic [31:0] magic_last;
        logic [31:0] byte_order;
        logic [31:0] format_code;
        logic [31:0] internal_format_code;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] faces;
        logic [31:0] levels;
        logic [31:0] kv_bytes;
        logic [31:0] file_bytes;
    } header_t;

    typedef struct {
        logic        accepted;
        logic [3:0]  kind;
        logic [31:0] payload_bytes;
        logic [32:0] payload_offset;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] levels;
    } result_t;

    class mip_scoreboard;
        result_t     expected_q[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Returns 0 when the code pair names no pixel kind.
        static function bit lookup_kind(input logic [31:0] fmt, input logic [31:0] ifmt,
                                        output pix_kind_t kind);
            bit hit;
            hit  = 1'b1;
            kind = PK_RGB;
            case (fmt)
                FMT_RGB:  kind = PK_RGB;
                FMT_RGBA: kind = PK_RGBA;
                FMT_BGRA: kind = PK_BGRA;
                FMT_COMPRESSED:
                begin
                    case (ifmt)
                        IFMT_ETC1:      kind = PK_ETC1;
                        IFMT_ETC2:      kind = PK_ETC2;
                        IFMT_ETC2_EAC:  kind = PK_ETC2_EAC;
                        IFMT_ETC2_A1:   kind = PK_ETC2_A1;
                        IFMT_PVR_RGB2:  kind = PK_PVR_RGB2;
                        IFMT_PVR_RGB4:  kind = PK_PVR_RGB4;
                        IFMT_PVR_RGBA2: kind = PK_PVR_RGBA2;
                        IFMT_PVR_RGBA4: kind = PK_PVR_RGBA4;
                        default:        hit = 1'b0;
                    endcase
                end
                default: hit = 1'b0;
            endcase
            return hit;
        endfunction

        // Byte size of one level; every product wraps at 32 bits.
        static function logic [31:0] level_size(input pix_kind_t kind, input logic [31:0] w,
                                                input logic [31:0] h);
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] area;
            logic [31:0] t;
            logic [31:0] res;
            a = w;
            b = h;
            case (kind)
                PK_RGB, PK_RGBA, PK_BGRA:
                begin
                end
                PK_PVR_RGB2, PK_PVR_RGBA2:
                begin
                    a = (w > 32'd16) ? w : 32'd16;
                    b = (h > 32'd8) ? h : 32'd8;
                end
                PK_PVR_RGB4, PK_PVR_RGBA4:
                begin
                    a = (w > 32'd8) ? w : 32'd8;
                    b = (h > 32'd8) ? h : 32'd8;
                end
                default:
                begin
                    // ETC works on 4x4 blocks; the +3 wraps before the shift.
                    a = w + 32'd3;
                    a = a >> 2;
                    b = h + 32'd3;
                    b = b >> 2;
                end
            endcase
            area = a * b;
            case (kind)
                PK_RGB:           res = area * 32'd3;
                PK_RGBA, PK_BGRA: res = area * 32'd4;
                PK_PVR_RGB2, PK_PVR_RGBA2:
                begin
                    t   = area * 32'd2 + 32'd7;
                    res = t / 32'd8;
                end
                PK_PVR_RGB4, PK_PVR_RGBA4:
                begin
                    t   = area * 32'd4 + 32'd7;
                    res = t / 32'd8;
                end
                PK_ETC2_EAC:      res = area * 32'd16;
                default:          res = area * 32'd8;
            endcase
            return res;
        endfunction

        // Sum over the whole mip chain plus the 4-byte size word per level.
        static function logic [31:0] chain_bytes(input pix_kind_t kind, input logic [31:0] w,
                                                 input logic [31:0] h,
                                                 input logic [31:0] levels);
            logic [31:0] sum;
            logic [31:0] cw;
            logic [31:0] ch;
            logic [31:0] steps;
            logic [31:0] extra;
            sum   = 32'd0;
            cw    = w;
            ch    = h;
            steps = (levels < 32'(SETTLE_LEVELS)) ? levels : 32'(SETTLE_LEVELS);
            for (int unsigned i = 0; i < steps; i++)
            begin
                sum += level_size(kind, cw, ch);
                cw = (cw > 32'd1) ? cw / 32'd2 : 32'd1;
                ch = (ch > 32'd1) ? ch / 32'd2 : 32'd1;
            end
            // By now both dimensions are 1, so the remaining levels are all 1x1.
            if (levels > 32'(SETTLE_LEVELS))
            begin
                extra = (levels - 32'(SETTLE_LEVELS)) * level_size(kind, 32'd1, 32'd1);
                sum += extra;
            end
            sum += levels * 32'd4;
            return sum;
        endfunction

        function result_t predict(input header_t hd);
            result_t     r;
            pix_kind_t   kind;
            logic [31:0] sum;
            logic [33:0] need;
            bit          ok;
            r  = '{default: '0};
            ok = lookup_kind(hd.format_code, hd.internal_format_code, kind);
            ok = ok && (hd.file_bytes >= MIN_FILE_BYTES) && (hd.magic_first == MAGIC_FIRST)
                    && (hd.magic_last == MAGIC_LAST) && (hd.byte_order == BYTE_ORDER)
                    && (hd.faces == 32'd1) && (hd.levels != 32'd0);
            if (!ok)
                return r;
            sum  = chain_bytes(kind, hd.width, hd.height, hd.levels);
            // The fit test itself does not wrap.
            need = 34'(HDR_BYTES) + 34'(hd.kv_bytes) + 34'(sum);
            if (need > 34'(hd.file_bytes))
                return r;
            r.accepted       = 1'b1;
            r.kind           = kind;
            r.payload_bytes  = sum;
            r.payload_offset = 33'(HDR_BYTES) + 33'(hd.kv_bytes);
            r.width          = hd.width;
            r.height         = hd.height;
            r.levels         = hd.levels;
            return r;
        endfunction

        function void note_header(input header_t hd);
            expected_q.push_back(predict(hd));
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void compare_field(input string field, input longint unsigned stamp,
                                    input logic [63:0] want_v, input logic [63:0] got_v);
            if (want_v !== got_v)
            begin
                mismatches++;
                $display("%0d ns: %s mismatch: expected %0h, actual %0h",
                         stamp, field, want_v, got_v);
            end
        endfunction

        function void check_result(input result_t got, input longint unsigned stamp);
            result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0d ns: result beat with no header outstanding: %s%0b",
                         stamp, "expected none, actual accepted=", got.accepted);
                return;
            end
            want = expected_q.pop_front();
            compare_field("accepted", stamp, 64'(want.accepted), 64'(got.accepted));
            compare_field("pixel_kind", stamp, 64'(want.kind), 64'(got.kind));
            compare_field("payload_bytes", stamp, 64'(want.payload_bytes),
                          64'(got.payload_bytes));
            compare_field("payload_offset", stamp, 64'(want.payload_offset),
                          64'(got.payload_offset));
            compare_field("out_width", stamp, 64'(want.width), 64'(got.width));
            compare_field("out_height", stamp, 64'(want.height), 64'(got.height));
            compare_field("out_levels", stamp, 64'(want.levels), 64'(got.levels));
        endfunction
    endclass

endpackage

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives texture headers into the header checker and mip-size calculator and
// checks every result beat against the scoreboard's prediction. A short
// directed run covers each pixel kind, every reject reason, zero and maximum
// dimensions, long mip chains and the file-fit boundary; random headers follow,
// most of them well formed with a file size chosen near the fit limit.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import thc_pkg::*;
    import thc_tb_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1350;
    localparam int unsigned DRAIN_EVERY  = 450;
    localparam int unsigned TAIL_CYCLES  = 40;

    // Format codes that name no pixel kind.
    localparam logic [31:0] FMT_UNLISTED  = 32'h0000_1234;
    localparam logic [31:0] IFMT_UNLISTED = 32'h0000_8D65;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    typedef enum logic [2:0] {
        FLAW_MAGIC_FIRST,
        FLAW_MAGIC_LAST,
        FLAW_BYTE_ORDER,
        FLAW_FACES,
        FLAW_FORMAT,
        FLAW_INTERNAL_FORMAT,
        FLAW_NO_LEVELS,
        FLAW_SHORT_FILE
    } flaw_t;

    logic clk;
    logic rst_n;

    thc_hdr_if hdr_ch ();
    thc_res_if res_ch ();

    mip_scoreboard sb = new();

    texture_header_check_and_mip_size i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr_ch),
        .res   (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Header beat builders.

    function automatic header_t well_formed(input pix_kind_t kind, input logic [31:0] w,
                                            input logic [31:0] hgt, input logic [31:0] levels);
        header_t hd;
        hd.magic_first          = MAGIC_FIRST;
        hd.magic_last           = MAGIC_LAST;
        hd.byte_order           = BYTE_ORDER;
        hd.format_code          = FMT_COMPRESSED;
        hd.internal_format_code = $urandom;
        case (kind)
            PK_RGB:       hd.format_code = FMT_RGB;
            PK_RGBA:      hd.format_code = FMT_RGBA;
            PK_BGRA:      hd.format_code = FMT_BGRA;
            PK_ETC1:      hd.internal_format_code = IFMT_ETC1;
            PK_ETC2:      hd.internal_format_code = IFMT_ETC2;
            PK_ETC2_EAC:  hd.internal_format_code = IFMT_ETC2_EAC;
            PK_ETC2_A1:   hd.internal_format_code = IFMT_ETC2_A1;
            PK_PVR_RGB2:  hd.internal_format_code = IFMT_PVR_RGB2;
            PK_PVR_RGB4:  hd.internal_format_code = IFMT_PVR_RGB4;
            PK_PVR_RGBA2: hd.internal_format_code = IFMT_PVR_RGBA2;
            default:      hd.internal_format_code = IFMT_PVR_RGBA4;
        endcase
        hd.width      = w;
        hd.height     = hgt;
        hd.faces      = 32'd1;
        hd.levels     = levels;
        hd.kv_bytes   = 32'd0;
        hd.file_bytes = 32'hFFFF_FFFF;
        return hd;
    endfunction

    // Mostly small sizes, so the chains stay short, with a tail of huge ones.
    function automatic logic [31:0] pick_dim();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom_range(0, 64);
        if (pick < 85)
            return $urandom_range(65, 4096);
        if (pick < 95)
            return $urandom;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            return 32'd0;
        if (pick == 1)
            return 32'd1;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] pick_levels();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return $urandom_range(1, 12);
        if (pick < 75)
            return $urandom_range(13, 32);
        if (pick < 90)
            return $urandom_range(33, 40);
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_kv();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(0, 256);
        if (pick < 90)
            return $urandom_range(0, 65535);
        return $urandom;
    endfunction

    function automatic header_t random_header();
        header_t     hd;
        pix_kind_t   kind;
        logic [31:0] sum;
        logic [33:0] need;
        logic [33:0] roomy;
        int unsigned pick;
        kind        = pix_kind_t'(4'($urandom_range(0, 10)));
        hd          = well_formed(kind, pick_dim(), pick_dim(), pick_levels());
        hd.kv_bytes = pick_kv();

        // Put the file size near the point where the data just fits.
        sum  = sb.chain_bytes(kind, hd.width, hd.height, hd.levels);
        need = 34'(HDR_BYTES) + 34'(hd.kv_bytes) + 34'(sum);
        pick = $urandom_range(0, 99);
        if (need > 34'h0_FFFF_FFFF || pick >= 95)
            hd.file_bytes = $urandom;
        else if (pick < 70)
        begin
            roomy         = need + 34'($urandom_range(0, 64));
            hd.file_bytes = (roomy > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : roomy[31:0];
        end
        else if (pick < 85)
            hd.file_bytes = need[31:0];
        else
            hd.file_bytes = need[31:0] - 32'd1;

        // A share of headers is broken in one field or is plain noise.
        pick = $urandom_range(0, 99);
        if (pick >= 90)
        begin
            hd.magic_first          = {$urandom, $urandom};
            hd.magic_last           = $urandom;
            hd.byte_order           = $urandom;
            hd.format_code          = $urandom;
            hd.internal_format_code = $urandom;
            hd.faces                = $urandom;
            hd.levels               = $urandom;
            hd.kv_bytes             = $urandom;
            hd.file_bytes           = $urandom;
        end
        else if (pick >= 70)
        begin
            case (flaw_t'(3'($urandom_range(0, 7))))
                FLAW_MAGIC_FIRST:
                    hd.magic_first ^= {$urandom, $urandom} | (64'd1 << $urandom_range(0, 63));
                FLAW_MAGIC_LAST:
                    hd.magic_last ^= $urandom | (32'd1 << $urandom_range(0, 31));
                FLAW_BYTE_ORDER:
                    hd.byte_order ^= $urandom | (32'd1 << $urandom_range(0, 31));
                FLAW_FACES:
                    hd.faces = ($urandom_range(0, 1) == 0) ? 32'd6 : $urandom;
                FLAW_FORMAT:
                    hd.format_code = $urandom;
                FLAW_INTERNAL_FORMAT:
                begin
                    hd.format_code          = FMT_COMPRESSED;
                    hd.internal_format_code = $urandom;
                end
                FLAW_NO_LEVELS:
                    hd.levels = 32'd0;
                default:
                    hd.file_bytes = $urandom_range(0, 127);
            endcase
        end
        return hd;
    endfunction

    // Channel drivers. Every task starts and ends at a rising edge.

    task automatic drive_fields(input header_t hd);
        hdr_ch.magic_first          <= hd.magic_first;
        hdr_ch.magic_last           <= hd.magic_last;
        hdr_ch.byte_order_word      <= hd.byte_order;
        hdr_ch.format_code          <= hd.format_code;
        hdr_ch.internal_format_code <= hd.internal_format_code;
        hdr_ch.image_width          <= hd.width;
        hdr_ch.image_height         <= hd.height;
        hdr_ch.face_total           <= hd.faces;
        hdr_ch.level_total          <= hd.levels;
        hdr_ch.key_value_bytes      <= hd.kv_bytes;
        hdr_ch.file_bytes           <= hd.file_bytes;
    endtask

    // Ready is sampled at the falling edge, where nothing moves, and the beat
    // completes at the following rising edge.
    task automatic send_header(input header_t hd);
        drive_fields(hd);
        hdr_ch.valid <= 1'b1;
        do
            @(negedge clk);
        while (hdr_ch.ready !== 1'b1);
        sb.note_header(hd);
        @(posedge clk);
    endtask

    task automatic idle_cycles(input int unsigned n);
        hdr_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic drain();
        hdr_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        header_t     hd;
        logic [31:0] need;
        // Every pixel kind on an odd-sized chain.
        for (int k = 0; k <= 10; k++)
            send_header(well_formed(pix_kind_t'(4'(k)), 32'd37, 32'd19, 32'd6));

        // Largest base size: the area product wraps.
        send_header(well_formed(PK_RGBA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1));
        // Zero dimensions on the base level.
        send_header(well_formed(PK_ETC1, 32'd0, 32'd0, 32'd3));
        // Chains that end exactly at, and just past, the 34-level settle point,
        // then the largest level count.
        send_header(well_formed(PK_RGB, 32'd1024, 32'd1024, 32'd34));
        send_header(well_formed(PK_PVR_RGB2, 32'd5, 32'd3, 32'd35));
        send_header(well_formed(PK_ETC2_EAC, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));

        // Reject reasons, one at a time.
        send_header(well_formed(PK_BGRA, 32'd8, 32'd8, 32'd0));
        hd       = well_formed(PK_RGB, 32'd8, 32'd8, 32'd2);
        hd.faces = 32'd6;
        send_header(hd);
        hd             = well_formed(PK_RGB, 32'd8, 32'd8, 32'd2);
        hd.magic_first = MAGIC_FIRST ^ 64'd1;
        send_header(hd);
        hd            = well_formed(PK_RGB, 32'd8, 32'd8, 32'd2);
        hd.magic_last = MAGIC_LAST ^ 32'h8000_0000;
        send_header(hd);
        hd            = well_formed(PK_RGB, 32'd8, 32'd8, 32'd2);
        hd.byte_order = 32'h0102_0304;
        send_header(hd);
        hd             = well_formed(PK_RGB, 32'd8, 32'd8, 32'd2);
        hd.format_code = FMT_UNLISTED;
        send_header(hd);
        hd                      = well_formed(PK_ETC1, 32'd8, 32'd8, 32'd2);
        hd.internal_format_code = IFMT_UNLISTED;
        send_header(hd);

        // Minimum file size on a tiny texture.
        hd            = well_formed(PK_RGB, 32'd2, 32'd2, 32'd1);
        hd.file_bytes = MIN_FILE_BYTES - 32'd1;
        send_header(hd);
        hd.file_bytes = MIN_FILE_BYTES;
        send_header(hd);

        // Fit boundary: exactly fits, then one byte short.
        hd            = well_formed(PK_RGB, 32'd8, 32'd8, 32'd1);
        need          = HDR_BYTES + sb.chain_bytes(PK_RGB, 32'd8, 32'd8, 32'd1);
        hd.file_bytes = need;
        send_header(hd);
        hd.file_bytes = need - 32'd1;
        send_header(hd);

        // Key-value area near the top of the range: the offset needs 33 bits.
        hd          = well_formed(PK_ETC1, 32'd4, 32'd4, 32'd1);
        hd.kv_bytes = 32'hFFFF_FF00;
        send_header(hd);
        hd.kv_bytes = 32'hFFFF_FFFF;
        send_header(hd);
    endtask

    // Result side: the receiver stalls in spans of one pattern at a time.
    initial
    begin : rx_pattern
        rx_mode_t    mode;
        int unsigned span;
        int unsigned phase;
        res_ch.ready <= 1'b0;
        mode  = RX_OPEN;
        span  = 0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                mode = rx_mode_t'(2'($urandom_range(0, 3)));
                span = $urandom_range(40, 400);
            end
            span--;
            phase++;
            case (mode)
                RX_OPEN:   res_ch.ready <= 1'b1;
                RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: res_ch.ready <= ($urandom_range(0, 5) == 0);
                default:   res_ch.ready <= ((phase % 7) < 3);
            endcase
        end
    end

    // Result beats are taken at the falling edge before the accepting edge.
    always @(negedge clk)
    begin : res_monitor
        result_t got;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got.accepted       = res_ch.accepted;
            got.kind           = res_ch.pixel_kind;
            got.payload_bytes  = res_ch.payload_bytes;
            got.payload_offset = res_ch.payload_offset;
            got.width          = res_ch.out_width;
            got.height         = res_ch.out_height;
            got.levels         = res_ch.out_levels;
            sb.check_result(got, $time);
        end
    end

    // Header side: reset, directed headers, then random bursts.
    initial
    begin : stimulus
        header_t     blank;
        int unsigned burst;
        blank = '{default: '0};
        rst_n        <= 1'b0;
        hdr_ch.valid <= 1'b0;
        drive_fields(blank);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        burst = $urandom_range(1, 12);
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_header(random_header());
            burst--;
            if ((i % DRAIN_EVERY) == DRAIN_EVERY - 1 && i != RANDOM_ITEMS - 1)
            begin
                drain();
                burst = $urandom_range(1, 12);
            end
            else if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                // Some bursts run straight into the next one.
                if ($urandom_range(0, 9) < 7)
                    idle_cycles($urandom_range(1, 15));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
